// ===== src/olt_pkg.sv =====
// Package for the ordered list table: opcodes, status codes, sequencer states,
// the result record and default sizes. No dependencies.
package olt_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_VALUE_BITS = 32;

    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND       = 3'd0,
        OP_INSERT_AT    = 3'd1,
        OP_REMOVE_AT    = 3'd2,
        OP_REMOVE_RANGE = 3'd3,
        OP_REMOVE_VALUE = 3'd4,
        OP_INDEX_OF     = 3'd5,
        OP_READ_AT      = 3'd6,
        OP_CLEAR        = 3'd7
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD_INDEX = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_SCAN,
        S_FETCH,
        S_PLACE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status             status;
        logic [INDEX_W-1:0]  found_index;
        logic [DATA_W-1:0]   read_value;
        logic [COUNT_W-1:0]  count;
    } t_result;

endpackage

// ===== src/olt_mem.sv =====
// Entry store of the ordered list table: one write port and one read port
// with registered read data. Uses olt_pkg for the default sizes.
module olt_mem
    import olt_pkg::*;
#(
    parameter int DEPTH = DEF_CAPACITY,
    parameter int WIDTH = DEF_VALUE_BITS,
    parameter int AW    = $clog2(DEF_CAPACITY)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== src/olt_ctrl.sv =====
// Sequencer of the ordered list table: decodes an item, walks the entry store
// for shifts and searches, and keeps the entry count. Uses olt_pkg.
module olt_ctrl
    import olt_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int IW         = $clog2(DEF_CAPACITY)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_busy,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [INDEX_W-1:0]    i_position,
    input  logic [INDEX_W-1:0]    i_range_end,
    input  logic [DATA_W-1:0]     i_value,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res,
    output logic                  o_mem_we,
    output logic [IW-1:0]         o_mem_waddr,
    output logic [VALUE_BITS-1:0] o_mem_wdata,
    output logic                  o_mem_re,
    output logic [IW-1:0]         o_mem_raddr,
    input  logic [VALUE_BITS-1:0] i_mem_rdata
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

    t_state                r_state, n_state;
    t_opcode               r_op, n_op;
    logic [CW-1:0]         r_count, n_count;
    logic [VALUE_BITS-1:0] r_word, n_word;
    logic [IW-1:0]         r_rd_addr, n_rd_addr;
    logic [CW-1:0]         r_left, n_left;
    logic                  r_pend, n_pend;
    logic [IW-1:0]         r_pend_addr, n_pend_addr;
    logic                  r_up, n_up;
    logic [CW-1:0]         r_gap, n_gap;
    logic [IW-1:0]         r_ins_pos, n_ins_pos;
    t_status               r_status, n_status;
    logic [IW-1:0]         r_found, n_found;
    logic [DATA_W-1:0]     r_rdval, n_rdval;

    t_opcode               in_op;
    logic                  acc;
    logic                  full;
    logic [CMP_W-1:0]      pos_c, end_c, cnt_c;
    t_status               acc_status;
    logic [VALUE_BITS-1:0] in_word;
    logic [CW-1:0]         ins_tail;
    logic [IW-1:0]         d_first, d_last;
    logic [CW-1:0]         d_gap, d_tail;
    logic                  hit;
    logic [IW-1:0]         move_waddr;

    assign in_op   = t_opcode'(i_opcode);
    assign acc     = i_valid && (r_state == S_IDLE);
    assign full    = (r_count == CW'(CAPACITY));
    assign pos_c   = CMP_W'(i_position);
    assign end_c   = CMP_W'(i_range_end);
    assign cnt_c   = CMP_W'(r_count);
    assign in_word = VALUE_BITS'(i_value);
    assign ins_tail = r_count - CW'(i_position);
    assign hit     = r_pend && (i_mem_rdata == r_word);

    // Span to drop: from the item for index removals, from the match for a search.
    always_comb begin
        if (r_state == S_SCAN) begin
            d_first = r_pend_addr;
            d_last  = r_pend_addr;
        end else begin
            d_first = IW'(i_position);
            d_last  = (in_op == OP_REMOVE_RANGE) ? IW'(i_range_end) : IW'(i_position);
        end
    end

    assign d_gap  = CW'(d_last) - CW'(d_first) + CW'(1);
    assign d_tail = r_count - CW'(d_last) - CW'(1);
    assign move_waddr = r_up ? (r_pend_addr + IW'(1)) : (r_pend_addr - r_gap[IW-1:0]);

    always_comb begin
        unique case (in_op)
            OP_APPEND:       acc_status = full ? STAT_FULL : STAT_OK;
            OP_INSERT_AT:    acc_status = (pos_c > cnt_c) ? STAT_BAD_INDEX :
                                          (full ? STAT_FULL : STAT_OK);
            OP_REMOVE_AT:    acc_status = (pos_c >= cnt_c) ? STAT_BAD_INDEX : STAT_OK;
            OP_REMOVE_RANGE: acc_status = ((pos_c > end_c) || (end_c >= cnt_c)) ?
                                          STAT_BAD_INDEX : STAT_OK;
            OP_REMOVE_VALUE: acc_status = (r_count == '0) ? STAT_NOT_FOUND : STAT_OK;
            OP_INDEX_OF:     acc_status = (r_count == '0) ? STAT_NOT_FOUND : STAT_OK;
            OP_READ_AT:      acc_status = (pos_c >= cnt_c) ? STAT_BAD_INDEX : STAT_OK;
            OP_CLEAR:        acc_status = STAT_OK;
            default:         acc_status = STAT_OK;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (acc_status != STAT_OK) begin
                        n_state = S_DONE;
                    end else begin
                        unique case (in_op)
                            OP_APPEND, OP_CLEAR: n_state = S_DONE;
                            OP_INSERT_AT: n_state = (ins_tail == '0) ? S_DONE : S_MOVE;
                            OP_REMOVE_AT, OP_REMOVE_RANGE:
                                n_state = (d_tail == '0) ? S_DONE : S_MOVE;
                            OP_REMOVE_VALUE, OP_INDEX_OF: n_state = S_SCAN;
                            OP_READ_AT: n_state = S_FETCH;
                            default: n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_MOVE: begin
                if ((r_left == '0) && r_pend) begin
                    n_state = r_up ? S_PLACE : S_DONE;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = ((r_op == OP_REMOVE_VALUE) && (d_tail != '0)) ? S_MOVE : S_DONE;
                end else if ((r_left == '0) && r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_FETCH: n_state = S_DONE;
            S_PLACE: n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory port control.
    always_comb begin
        n_op        = r_op;
        n_count     = r_count;
        n_word      = r_word;
        n_rd_addr   = r_rd_addr;
        n_left      = r_left;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_up        = r_up;
        n_gap       = r_gap;
        n_ins_pos   = r_ins_pos;
        n_status    = r_status;
        n_found     = r_found;
        n_rdval     = r_rdval;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_ins_pos;
        o_mem_wdata = r_word;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_rd_addr;

        unique case (r_state)
            S_IDLE: begin
                o_mem_raddr = IW'(i_position);
                if (acc) begin
                    n_op     = in_op;
                    n_word   = in_word;
                    n_status = acc_status;
                    n_found  = '0;
                    n_rdval  = '0;
                    if (acc_status == STAT_OK) begin
                        unique case (in_op)
                            OP_APPEND: begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = IW'(r_count);
                                o_mem_wdata = in_word;
                                n_count     = r_count + CW'(1);
                            end
                            OP_INSERT_AT: begin
                                if (ins_tail == '0) begin
                                    o_mem_we    = 1'b1;
                                    o_mem_waddr = IW'(i_position);
                                    o_mem_wdata = in_word;
                                    n_count     = r_count + CW'(1);
                                end else begin
                                    n_rd_addr = IW'(r_count - CW'(1));
                                    n_left    = ins_tail;
                                    n_up      = 1'b1;
                                    n_gap     = CW'(1);
                                    n_ins_pos = IW'(i_position);
                                end
                            end
                            OP_REMOVE_AT, OP_REMOVE_RANGE: begin
                                if (d_tail == '0) begin
                                    n_count = r_count - d_gap;
                                end else begin
                                    n_rd_addr = d_last + IW'(1);
                                    n_left    = d_tail;
                                    n_up      = 1'b0;
                                    n_gap     = d_gap;
                                end
                            end
                            OP_REMOVE_VALUE, OP_INDEX_OF: begin
                                n_rd_addr = '0;
                                n_left    = r_count;
                            end
                            OP_READ_AT: begin
                                o_mem_re = 1'b1;
                            end
                            OP_CLEAR: begin
                                n_count = '0;
                            end
                            default: begin
                                n_count = r_count;
                            end
                        endcase
                    end
                end
            end
            S_MOVE: begin
                if (r_left != '0) begin
                    o_mem_re    = 1'b1;
                    n_rd_addr   = r_up ? (r_rd_addr - IW'(1)) : (r_rd_addr + IW'(1));
                    n_left      = r_left - CW'(1);
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr;
                end
                if (r_pend) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = move_waddr;
                    o_mem_wdata = i_mem_rdata;
                end
                if ((r_left == '0) && r_pend && !r_up) begin
                    n_count = r_count - r_gap;
                end
            end
            S_SCAN: begin
                if ((r_left != '0) && !hit) begin
                    o_mem_re    = 1'b1;
                    n_rd_addr   = r_rd_addr + IW'(1);
                    n_left      = r_left - CW'(1);
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr;
                end
                if (hit) begin
                    n_found = r_pend_addr;
                    if (r_op == OP_REMOVE_VALUE) begin
                        if (d_tail == '0) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            n_rd_addr = r_pend_addr + IW'(1);
                            n_left    = d_tail;
                            n_up      = 1'b0;
                            n_gap     = CW'(1);
                        end
                    end
                end else if ((r_left == '0) && r_pend) begin
                    n_status = STAT_NOT_FOUND;
                end
            end
            S_FETCH: begin
                n_rdval = DATA_W'(i_mem_rdata);
            end
            S_PLACE: begin
                o_mem_we = 1'b1;
                n_count  = r_count + CW'(1);
            end
            S_DONE: begin
                n_rdval = r_rdval;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_word      <= n_word;
        r_rd_addr   <= n_rd_addr;
        r_pend_addr <= n_pend_addr;
        r_up        <= n_up;
        r_gap       <= n_gap;
        r_ins_pos   <= n_ins_pos;
        r_status    <= n_status;
        r_found     <= n_found;
        r_rdval     <= n_rdval;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status      = r_status;
        o_res.found_index = INDEX_W'(r_found);
        o_res.read_value  = r_rdval;
        o_res.count       = COUNT_W'(r_count);
    end

endmodule

// ===== src/ordered_list_table.sv =====
// Top level of the ordered list table: sequencer, entry store and the output
// register. Depends on olt_pkg, olt_mem and olt_ctrl.
//
// The block keeps an ordered list of up to CAPACITY words in a single-port-
// write, single-port-read memory and performs one operation per item: append,
// insert at an index, remove at an index, remove an inclusive index range,
// remove the first entry equal to a value, find the first equal value, read
// at an index, or clear. Each item yields exactly one result with a status,
// the found index, the read word and the length after the operation. Items
// are handled one at a time. Append, clear and operations that fail their
// index checks go from acceptance to the done state and then to the result
// register; a read passes through a fetch state first. Insert and removal
// move every entry behind the affected place through the memory, one entry
// per cycle with registered read data; an insert writes the new word after
// the last move. Searches read entries from the head, one per cycle, until
// the first match, and a removal by value then shifts the tail as above.
// The output register lets the next item be accepted while a result is
// still waiting to be taken. Stored words are not cleared by reset or by
// clear; only entries below the length are ever read.
module ordered_list_table
    import olt_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [INDEX_W-1:0]  i_position,
    input  logic [INDEX_W-1:0]  i_range_end,
    input  logic [DATA_W-1:0]   i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [INDEX_W-1:0]  o_found_index,
    output logic [DATA_W-1:0]   o_read_value,
    output logic [COUNT_W-1:0]  o_count
);

    // Address width of the entry store.
    localparam int IW = $clog2(CAPACITY);

    logic                  busy;
    logic                  res_valid;
    logic                  res_ready;
    t_result               res;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [IW-1:0]         mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;

    olt_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .IW         (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_busy      (busy),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_range_end (i_range_end),
        .i_value     (i_value),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    olt_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The sequencer only hands over a result when the output register is
    // empty or is being emptied in the same cycle, so nothing is overwritten.
    assign res_ready = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // New items are taken only while the sequencer is idle.
    assign o_stall       = busy;
    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_found_index = r_out.found_index;
    assign o_read_value  = r_out.read_value;
    assign o_count       = r_out.count;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for ordered_list_table: a directed opening and then
// segmented random traffic, with random idling on both channels.
// Depends on olt_pkg and the ordered_list_table RTL.
module tb_top;
    import olt_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int MAX_IDLE    = 16;
    localparam int RAND_ITEMS  = 800;
    localparam int TAIL_CYCLES = 100;
    localparam int CYCLE_LIMIT = 400000;

    // Streams of the predictor: the stimulus generator runs its own copy of
    // the list ahead of time, and the checker replays each item on acceptance.
    localparam int GEN_LIST = 0;
    localparam int CHK_LIST = 1;

    typedef struct {
        t_opcode            opc;
        logic [INDEX_W-1:0] pos;
        logic [INDEX_W-1:0] last;
        logic [DATA_W-1:0]  word;
        int                 gap;
        bit                 drain;
    } t_list_op;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [OPCODE_W-1:0] i_opcode = '0;
    logic [INDEX_W-1:0]  i_position = '0;
    logic [INDEX_W-1:0]  i_range_end = '0;
    logic [DATA_W-1:0]   i_value = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [INDEX_W-1:0]  o_found_index;
    logic [DATA_W-1:0]   o_read_value;
    logic [COUNT_W-1:0]  o_count;

    // Two copies of the list contents and length, one per predictor stream.
    logic [DATA_W-1:0] list_mem [2][LIST_DEPTH];
    int                list_len [2];

    t_list_op queued_ops[$];
    t_result  pending_results[$];
    t_list_op cur_op;

    bit in_taken    = 1'b0;
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    bit next_drain  = 1'b0;
    int idle_waited = 0;
    int rx_hold     = 0;
    int error_count = 0;
    int cycle_count = 0;

    ordered_list_table DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_position    (i_position),
        .i_range_end   (i_range_end),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_read_value  (o_read_value),
        .o_count       (o_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Closes the gap left by a removal of entries lo..hi inclusive.
    function automatic void drop_entries(int s, int lo, int hi);
        int span;
        int i;
        span = hi - lo + 1;
        for (i = lo; i + span < list_len[s]; i++) begin
            list_mem[s][i] = list_mem[s][i + span];
        end
        list_len[s] -= span;
    endfunction

    // Applies one item to the chosen copy of the list and returns the result
    // that the block must give for it.
    function automatic t_result apply_list_op(int s, t_list_op it);
        t_result r;
        int      n;
        int      p;
        int      e;
        int      hit;
        int      i;
        r   = '0;
        n   = list_len[s];
        p   = int'(it.pos);
        e   = int'(it.last);
        hit = -1;
        r.status = STAT_OK;
        // Both searches take the first equal entry, never one past the length.
        for (i = 0; i < n; i++) begin
            if (hit < 0 && list_mem[s][i] == it.word) begin
                hit = i;
            end
        end
        case (it.opc)
            OP_APPEND: begin
                if (n >= LIST_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    list_mem[s][n] = it.word;
                    list_len[s]    = n + 1;
                end
            end
            OP_INSERT_AT: begin
                // An index past the end outranks a full list.
                if (p > n) begin
                    r.status = STAT_BAD_INDEX;
                end else if (n >= LIST_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    for (i = n; i > p; i--) begin
                        list_mem[s][i] = list_mem[s][i - 1];
                    end
                    list_mem[s][p] = it.word;
                    list_len[s]    = n + 1;
                end
            end
            OP_REMOVE_AT: begin
                if (p >= n) begin
                    r.status = STAT_BAD_INDEX;
                end else begin
                    drop_entries(s, p, p);
                end
            end
            OP_REMOVE_RANGE: begin
                if (p > e || e >= n) begin
                    r.status = STAT_BAD_INDEX;
                end else begin
                    drop_entries(s, p, e);
                end
            end
            OP_REMOVE_VALUE: begin
                if (hit < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    r.found_index = INDEX_W'(hit);
                    drop_entries(s, hit, hit);
                end
            end
            OP_INDEX_OF: begin
                if (hit < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    r.found_index = INDEX_W'(hit);
                end
            end
            OP_READ_AT: begin
                if (p >= n) begin
                    r.status = STAT_BAD_INDEX;
                end else begin
                    r.read_value = list_mem[s][p];
                end
            end
            default: begin
                // Clear only resets the length; the stored words stay put.
                list_len[s] = 0;
            end
        endcase
        r.count = COUNT_W'(list_len[s]);
        return r;
    endfunction

    // Appends one item to the stimulus queue and advances the generator's
    // copy of the list so that later items can aim at valid indexes.
    task automatic queue_op(t_opcode opc, int pos, int last, logic [DATA_W-1:0] word);
        t_list_op it;
        it.opc   = opc;
        it.pos   = INDEX_W'(pos);
        it.last  = INDEX_W'(last);
        it.word  = word;
        it.gap   = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
        it.drain = next_drain;
        next_drain = 1'b0;
        queued_ops.push_back(it);
        void'(apply_list_op(GEN_LIST, it));
    endtask

    // Mostly a few small words so that searches find duplicates, sometimes
    // words near the top, and otherwise any word at all.
    function automatic logic [DATA_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            return DATA_W'($urandom_range(0, 7));
        end else if (sel == 5) begin
            return ~DATA_W'($urandom_range(0, 3));
        end
        return $urandom();
    endfunction

    // An index below span most of the time, any index now and then.
    function automatic int pick_index(int span);
        if (span <= 0 || $urandom_range(0, 4) == 0) begin
            return $urandom_range(0, LIST_DEPTH - 1);
        end
        return $urandom_range(0, (span > LIST_DEPTH ? LIST_DEPTH : span) - 1);
    endfunction

    // A word that is in the list when there is one, so searches usually hit.
    function automatic logic [DATA_W-1:0] pick_present_word();
        int n;
        n = list_len[GEN_LIST];
        if (n == 0 || $urandom_range(0, 3) == 0) begin
            return pick_word();
        end
        return list_mem[GEN_LIST][$urandom_range(0, n - 1)];
    endfunction

    // Driver: a new item goes out at the falling edge once the previous one
    // has been taken and its idle gap has run out. An item marked for
    // draining waits until every expected result has come back.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // Stalled: hold the item as it is.
        end else if (queued_ops.size() == 0) begin
            i_valid <= 1'b0;
        end else if (idle_waited < queued_ops[0].gap ||
                     (queued_ops[0].drain && pending_results.size() != 0)) begin
            i_valid <= 1'b0;
            idle_waited++;
        end else begin
            cur_op      = queued_ops.pop_front();
            idle_waited = 0;
            i_valid     <= 1'b1;
            i_opcode    <= cur_op.opc;
            i_position  <= cur_op.pos;
            i_range_end <= cur_op.last;
            i_value     <= cur_op.word;
        end
    end

    // Receiver: after each result it holds stall high for a drawn number of
    // cycles, whether or not the next result is there yet.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: on acceptance of an item the expected result is queued; each
    // result taken is compared field by field with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) begin
            pending_results.push_back(apply_list_op(CHK_LIST, cur_op));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no item outstanding: status %0d count %0d",
                       o_status, o_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_found_index !== want.found_index) begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, o_found_index);
                    error_count++;
                end
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value, o_read_value);
                    error_count++;
                end
                if (o_count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_count);
                    error_count++;
                end
            end
            // Switch now and then between stretches with and without stalls.
            if ($urandom_range(0, 39) == 0) begin
                rx_calm = !rx_calm;
            end
            rx_hold = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int made;
        int kind;
        int seg_len;
        int n;
        int p;
        int sel;
        list_len[GEN_LIST] = 0;
        list_len[CHK_LIST] = 0;

        // Directed opening: every operation but append on an empty list, insertion at
        // the head, the middle and the end, duplicates, reads at the last
        // index and just past it, both kinds of bad range, and clear.
        queue_op(OP_READ_AT, 0, 0, '0);
        queue_op(OP_REMOVE_AT, 0, 0, '0);
        queue_op(OP_REMOVE_VALUE, 0, 0, '0);
        queue_op(OP_INDEX_OF, 0, 0, '1);
        queue_op(OP_REMOVE_RANGE, 0, 0, '0);
        queue_op(OP_INSERT_AT, 1, 0, 32'h1234_5678);
        queue_op(OP_INSERT_AT, 0, 0, '1);
        queue_op(OP_APPEND, 0, 0, '0);
        queue_op(OP_APPEND, 0, 0, 32'h8000_0001);
        queue_op(OP_INSERT_AT, 1, 0, 32'h5555_5555);
        queue_op(OP_INSERT_AT, 0, 0, 32'hAAAA_AAAA);
        queue_op(OP_APPEND, 0, 0, '0);
        queue_op(OP_INDEX_OF, 0, 0, '0);
        queue_op(OP_READ_AT, 5, 0, '0);
        queue_op(OP_READ_AT, 6, 0, '0);
        queue_op(OP_READ_AT, 63, 63, '1);
        queue_op(OP_REMOVE_VALUE, 0, 0, '0);
        queue_op(OP_REMOVE_RANGE, 3, 1, '0);
        queue_op(OP_REMOVE_RANGE, 1, 63, '0);
        queue_op(OP_REMOVE_RANGE, 1, 2, '0);
        queue_op(OP_REMOVE_AT, 2, 0, '0);
        queue_op(OP_REMOVE_AT, 0, 0, '0);
        queue_op(OP_CLEAR, 0, 0, '0);
        queue_op(OP_READ_AT, 0, 0, '0);
        queue_op(OP_CLEAR, 63, 63, '1);

        // Random part in segments: growing to full and beyond, shrinking,
        // and mixed traffic. The first segment, and some later ones, start
        // only once every earlier result has come back.
        made = 0;
        while (made < RAND_ITEMS) begin
            kind       = $urandom_range(0, 3);
            tx_calm    = ($urandom_range(0, 3) == 0);
            next_drain = (made == 0) || ($urandom_range(0, 3) == 0);
            if (kind == 0) begin
                seg_len = LIST_DEPTH - list_len[GEN_LIST] + $urandom_range(1, 4);
            end else begin
                seg_len = $urandom_range(10, 50);
            end
            repeat (seg_len) begin
                n   = list_len[GEN_LIST];
                sel = $urandom_range(0, 2);
                case (kind)
                    0: begin
                        // Growth at valid places; once full these give full.
                        if (sel == 0) begin
                            queue_op(OP_APPEND, pick_index(0), pick_index(0), pick_word());
                        end else begin
                            p = (n >= LIST_DEPTH) ? pick_index(0) : $urandom_range(0, n);
                            queue_op(OP_INSERT_AT, p, pick_index(0), pick_word());
                        end
                    end
                    1: begin
                        if (sel == 0) begin
                            queue_op(OP_REMOVE_AT, pick_index(n), pick_index(0), pick_word());
                        end else if (sel == 1) begin
                            p = pick_index(n);
                            queue_op(OP_REMOVE_RANGE, p,
                                     ($urandom_range(0, 4) == 0) ? pick_index(0)
                                         : p + $urandom_range(0, 3),
                                     pick_word());
                        end else begin
                            queue_op(OP_REMOVE_VALUE, pick_index(0), pick_index(0),
                                     pick_present_word());
                        end
                    end
                    default: begin
                        if ($urandom_range(0, 39) == 0) begin
                            queue_op(OP_CLEAR, pick_index(0), pick_index(0), pick_word());
                        end else begin
                            p = pick_index(n + 1);
                            queue_op(t_opcode'($urandom_range(0, 6)), p,
                                     ($urandom_range(0, 2) == 0) ? pick_index(0)
                                         : p + $urandom_range(0, 4),
                                     pick_present_word());
                        end
                    end
                endcase
                made++;
            end
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Let the driver empty its queue and the last item go out, then wait
        // for the last results and a stretch of quiet longer than the slowest
        // operation.
        wait (queued_ops.size() == 0);
        @(posedge i_clk);
        wait (!i_valid && pending_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/olt_pkg.sv
src/olt_mem.sv
src/olt_ctrl.sv
src/ordered_list_table.sv
tb/tb_top.sv
